[hdl/matrix3_inverse_top_assert.svh]
// Assertion macros for the 3x3 matrix inverse block.
`ifndef MATRIX3_INVERSE_TOP_ASSERT_SVH
`define MATRIX3_INVERSE_TOP_ASSERT_SVH

// Plain implication checked at every clock edge outside reset.
`define M3I_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a fixed delay in cycles.
`define M3I_ASSERT_DELAY(lbl, ante, cons, n, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

[hdl/m3inv_pkg.sv]
// Shared constants for the 3x3 matrix inverse block.
`timescale 1ns / 1ps
package m3inv_pkg;

  localparam int NUM_ENT = 9;

  typedef logic [3:0] idx_t;

  // Cofactor i is m[c0]*m[c1] - m[c2]*m[c3], entries in row-major order.
  localparam idx_t COF_IDX [NUM_ENT][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  // First-row expansion: det = sum of m[k] * cofactor DET_COF[k].
  localparam idx_t DET_COF [3] = '{4'd0, 4'd3, 4'd6};

  localparam int THR_WIDTH = 32;

endpackage

[hdl/matrix3_inverse_top.sv]
// Top level of the pipelined 3x3 fixed-point matrix inverse.
`timescale 1ns / 1ps
// Usage of matrix3_inverse_top.
// An item is one 3x3 matrix of signed entries with FRAC_BITS fraction bits,
// presented on a00_i..a22_i and taken at a rising edge where start_i is high
// and busy_o is low. The block is fully pipelined, so busy_o is always low and
// a new item may be taken in every cycle.
// Each item yields one result on b00_o..b22_o and singular_o, shown for
// exactly one cycle with done_o high. Results leave in the order the items
// came in. The divider takes one restoring step per quotient bit, one
// pipeline stage each, nine lanes side by side, after stages that form
// products, cofactors, the determinant and the singular test.
// The receiver cannot stall, so no back pressure exists anywhere in the block.
// When the determinant magnitude is below the threshold (or is zero) the
// matrix is flagged singular and the input entries come back unchanged.
// Otherwise each entry is the cofactor over the determinant, truncated toward
// zero and saturated to the entry range.
// The threshold register is written through cfg_we_i / cfg_wdata_i; the user
// must do so only while the block is idle, which the block does not enforce.
// Reset clears all valid bits and sets the threshold to one.
module matrix3_inverse_top #(
  parameter int FRAC_BITS   = 16,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          cfg_we_i,
  input  logic [m3inv_pkg::THR_WIDTH-1:0] cfg_wdata_i,
  input  logic signed [ENTRY_WIDTH-1:0] a00_i,
  input  logic signed [ENTRY_WIDTH-1:0] a01_i,
  input  logic signed [ENTRY_WIDTH-1:0] a02_i,
  input  logic signed [ENTRY_WIDTH-1:0] a10_i,
  input  logic signed [ENTRY_WIDTH-1:0] a11_i,
  input  logic signed [ENTRY_WIDTH-1:0] a12_i,
  input  logic signed [ENTRY_WIDTH-1:0] a20_i,
  input  logic signed [ENTRY_WIDTH-1:0] a21_i,
  input  logic signed [ENTRY_WIDTH-1:0] a22_i,
  output logic                          done_o,
  output logic signed [ENTRY_WIDTH-1:0] b00_o,
  output logic signed [ENTRY_WIDTH-1:0] b01_o,
  output logic signed [ENTRY_WIDTH-1:0] b02_o,
  output logic signed [ENTRY_WIDTH-1:0] b10_o,
  output logic signed [ENTRY_WIDTH-1:0] b11_o,
  output logic signed [ENTRY_WIDTH-1:0] b12_o,
  output logic signed [ENTRY_WIDTH-1:0] b20_o,
  output logic signed [ENTRY_WIDTH-1:0] b21_o,
  output logic signed [ENTRY_WIDTH-1:0] b22_o,
  output logic                          singular_o
);

  `include "matrix3_inverse_top_assert.svh"

  localparam int EW = ENTRY_WIDTH;
  localparam int NE = m3inv_pkg::NUM_ENT;
  localparam int TW = m3inv_pkg::THR_WIDTH;
  localparam int PW = 2 * EW;              // entry product
  localparam int CW = 2 * EW + 1;          // cofactor
  localparam int QW = 2 * EW + 1;          // partial product of entry and cofactor half
  localparam int DW = 3 * EW + 3;          // determinant
  localparam int NW = CW + 2 * FRAC_BITS;  // shifted cofactor magnitude
  localparam int XW = (NW > DW + EW) ? NW : DW + EW;
  localparam int LW = (DW > TW + FRAC_BITS) ? DW : TW + FRAC_BITS;
  localparam int LATENCY = EW + 8;

  logic [TW-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= TW'(1);
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  assign busy_o = 1'b0;

  logic signed [EW-1:0] mat_in [NE];
  assign mat_in = '{a00_i, a01_i, a02_i, a10_i, a11_i, a12_i, a20_i, a21_i, a22_i};

  // Valid bits of the front stages and of the divider stages.
  logic [6:1] vf_q;
  logic       vd_q [EW+1];
  logic       done_q;

  // Front stage payload.
  logic signed [EW-1:0] mat1_q [NE], mat2_q [NE], mat3_q [NE];
  logic signed [EW-1:0] mat4_q [NE], mat5_q [NE], mat6_q [NE];
  logic signed [PW-1:0] prod_q [2*NE], prod_d [2*NE];
  logic signed [CW-1:0] cof2_q [NE], cof2_d [NE];
  logic signed [CW-1:0] cof3_q [NE], cof4_q [NE], cof5_q [NE], cof6_q [NE];
  logic signed [QW-1:0] pph_q [3], pph_d [3], ppl_q [3], ppl_d [3];
  logic signed [DW-1:0] term_q [3], term_d [3];
  logic signed [DW-1:0] det_q, det_d;
  logic [DW-1:0]        adet_q, adet_d;
  logic                 dneg_q, dneg_d, sing6_q, sing6_d;

  // Divider payload; index zero holds the prepared dividends.
  logic [XW-1:0]        rem_q [EW+1][NE], rem_d [EW+1][NE];
  logic [EW-1:0]        quo_q [EW+1][NE], quo_d [EW+1][NE];
  logic [NE-1:0]        neg_q [EW+1], neg_d [EW+1];
  logic [NE-1:0]        sat_q [EW+1], sat_d [EW+1];
  logic [DW-1:0]        dvs_q [EW+1];
  logic                 sing_q [EW+1];
  logic signed [EW-1:0] matd_q [EW+1][NE];

  logic signed [EW-1:0] res_q [NE], res_d [NE];
  logic                 sing_out_q;

  // Products, cofactors and the determinant.
  always_comb begin
    logic [EW-1:0]        lo;
    logic signed [EW:0]   hi;
    logic signed [CW-1:0] cf;
    for (int i = 0; i < NE; i++) begin
      prod_d[2*i]   = mat_in[m3inv_pkg::COF_IDX[i][0]] * mat_in[m3inv_pkg::COF_IDX[i][1]];
      prod_d[2*i+1] = mat_in[m3inv_pkg::COF_IDX[i][2]] * mat_in[m3inv_pkg::COF_IDX[i][3]];
      cof2_d[i] = CW'(prod_q[2*i]) - CW'(prod_q[2*i+1]);
    end
    for (int k = 0; k < 3; k++) begin
      cf = cof2_q[m3inv_pkg::DET_COF[k]];
      lo = cf[EW-1:0];
      hi = cf[CW-1:EW];
      ppl_d[k]  = mat2_q[k] * $signed({1'b0, lo});
      pph_d[k]  = mat2_q[k] * hi;
      term_d[k] = (DW'(pph_q[k]) <<< EW) + DW'(ppl_q[k]);
    end
    det_d   = term_q[0] + term_q[1] + term_q[2];
    dneg_d  = det_q[DW-1];
    adet_d  = dneg_d ? DW'(-det_q) : DW'(det_q);
    sing6_d = (det_q == '0) || (LW'(adet_d) < (LW'(thr_q) << FRAC_BITS));
  end

  // Dividend setup and one restoring step per divider stage.
  always_comb begin
    logic [CW-1:0] acf;
    logic [XW-1:0] dsh;
    for (int l = 0; l < NE; l++) begin
      acf = cof6_q[l][CW-1] ? CW'(-cof6_q[l]) : CW'(cof6_q[l]);
      rem_d[0][l] = XW'(acf) << (2 * FRAC_BITS);
      quo_d[0][l] = '0;
      neg_d[0][l] = cof6_q[l][CW-1] ^ dneg_q;
      sat_d[0][l] = rem_d[0][l] >= (XW'(adet_q) << EW);
    end
    for (int j = 1; j <= EW; j++) begin
      neg_d[j] = neg_q[j-1];
      sat_d[j] = sat_q[j-1];
      for (int l = 0; l < NE; l++) begin
        dsh = XW'(dvs_q[j-1]) << (EW - j);
        quo_d[j][l] = quo_q[j-1][l];
        if (rem_q[j-1][l] >= dsh) begin
          rem_d[j][l] = rem_q[j-1][l] - dsh;
          quo_d[j][l][EW-j] = 1'b1;
        end else begin
          rem_d[j][l] = rem_q[j-1][l];
        end
      end
    end
  end

  // Sign, saturation and the singular bypass.
  always_comb begin
    logic [EW-1:0] q;
    for (int l = 0; l < NE; l++) begin
      q = quo_q[EW][l];
      if (sing_q[EW]) begin
        res_d[l] = matd_q[EW][l];
      end else if (!neg_q[EW][l]) begin
        if (sat_q[EW][l] || q[EW-1]) begin
          res_d[l] = {1'b0, {(EW-1){1'b1}}};
        end else begin
          res_d[l] = $signed(q);
        end
      end else begin
        if (sat_q[EW][l] || (q > {1'b1, {(EW-1){1'b0}}})) begin
          res_d[l] = {1'b1, {(EW-1){1'b0}}};
        end else begin
          res_d[l] = $signed(-q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q   <= '0;
      done_q <= 1'b0;
      for (int j = 0; j <= EW; j++) begin
        vd_q[j] <= 1'b0;
      end
    end else begin
      vf_q   <= {vf_q[5:1], start_i && !busy_o};
      vd_q[0] <= vf_q[6];
      for (int j = 1; j <= EW; j++) begin
        vd_q[j] <= vd_q[j-1];
      end
      done_q <= vd_q[EW];
    end
  end

  always_ff @(posedge clk_i) begin
    mat1_q  <= mat_in;
    prod_q  <= prod_d;
    mat2_q  <= mat1_q;
    cof2_q  <= cof2_d;
    mat3_q  <= mat2_q;
    cof3_q  <= cof2_q;
    pph_q   <= pph_d;
    ppl_q   <= ppl_d;
    mat4_q  <= mat3_q;
    cof4_q  <= cof3_q;
    term_q  <= term_d;
    mat5_q  <= mat4_q;
    cof5_q  <= cof4_q;
    det_q   <= det_d;
    mat6_q  <= mat5_q;
    cof6_q  <= cof5_q;
    adet_q  <= adet_d;
    dneg_q  <= dneg_d;
    sing6_q <= sing6_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    neg_q   <= neg_d;
    sat_q   <= sat_d;
    dvs_q[0]  <= adet_q;
    sing_q[0] <= sing6_q;
    matd_q[0] <= mat6_q;
    for (int j = 1; j <= EW; j++) begin
      dvs_q[j]  <= dvs_q[j-1];
      sing_q[j] <= sing_q[j-1];
      matd_q[j] <= matd_q[j-1];
    end
    res_q      <= res_d;
    sing_out_q <= sing_q[EW];
  end

  assign done_o     = done_q;
  assign singular_o = sing_out_q;
  assign b00_o = res_q[0];
  assign b01_o = res_q[1];
  assign b02_o = res_q[2];
  assign b10_o = res_q[3];
  assign b11_o = res_q[4];
  assign b12_o = res_q[5];
  assign b20_o = res_q[6];
  assign b21_o = res_q[7];
  assign b22_o = res_q[8];

  // Every accepted item comes out after the fixed pipeline latency.
  `M3I_ASSERT_DELAY(a_latency, start_i && !busy_o, done_o, LATENCY, "item result missing")
  // No result appears without an item taken that many cycles earlier.
  `M3I_ASSERT_IMPL(a_no_phantom, done_o, $past(start_i, LATENCY), "result without item")

endmodule
